>>> hdl/kwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

    localparam int KMER_LEN       = 19;
    localparam int WINDOW_LEN     = 5;
    localparam int BASES_PER_BYTE = 4;

    localparam int BYTE_W     = 8;
    localparam int NB_W       = 3;
    localparam int BASE_IDX_W = 2;
    localparam int KMER_W     = 2 * KMER_LEN;
    localparam int OUT_KMER_W = 38;
    localparam int POS_W      = 40;
    localparam int KIDX_W     = 32;
    localparam int SEEN_W     = $clog2(KMER_LEN + 1);
    localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
    localparam int WIN_IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    typedef logic [KMER_W-1:0] t_kmer;

    // One full k-mer moving down the pipe
    typedef struct packed {
        logic              valid;
        logic              emit;
        logic              last;
        t_kmer             kmer;
        t_kmer             hash;
        logic [KIDX_W-1:0] idx0;
        logic [POS_W-1:0]  rbase;
    } t_beat;

    typedef struct packed {
        logic [OUT_KMER_W-1:0] minimizer_kmer;
        logic [POS_W-1:0]      position;
        logic                  last_of_run;
    } t_result;

    // First half of the invertible mix: steps 21, 24, 3+8
    function automatic t_kmer mix_head(input t_kmer k);
        t_kmer a;
        t_kmer b;
        a = ~k + (k << 21);
        b = a ^ (a >> 24);
        return b + (b << 3) + (b << 8);
    endfunction

    // Second half: steps 14, 2+4, 28, 31
    function automatic t_kmer mix_tail(input t_kmer k);
        t_kmer a;
        t_kmer b;
        t_kmer c;
        a = k ^ (k >> 14);
        b = a + (a << 2) + (a << 4);
        c = b ^ (b >> 28);
        return c + (c << 31);
    endfunction

endpackage

`default_nettype wire

>>> hdl/kwm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kwm_in_if;
    logic                          valid;
    logic                          ready;
    logic [kwm_pkg::BYTE_W-1:0]    packed_byte;
    logic [kwm_pkg::NB_W-1:0]      bases_valid;
    logic                          first_of_sequence;
    logic [kwm_pkg::POS_W-1:0]     record_offset;

    modport source (output valid, packed_byte, bases_valid, first_of_sequence,
                    record_offset, input ready);
    modport sink   (input valid, packed_byte, bases_valid, first_of_sequence,
                    record_offset, output ready);
endinterface

interface kwm_out_if;
    logic                            valid;
    logic                            ready;
    logic [kwm_pkg::OUT_KMER_W-1:0]  minimizer_kmer;
    logic [kwm_pkg::POS_W-1:0]       position;
    logic                            last_of_run;

    modport source (output valid, minimizer_kmer, position, last_of_run, input ready);
    modport sink   (input valid, minimizer_kmer, position, last_of_run, output ready);
endinterface

`default_nettype wire

>>> hdl/kmer_window_minimizer_top.sv
// Results pass the byte, feed, hash, window and output registers in that order.
// Throughput: one base per cycle while the pipe is not held; a byte with no bases still
//   occupies the base feed, and at most one result leaves per cycle.
// The pipe holds as a whole while a result waits to be taken.
// Reset: synchronous, active low; clears sequence state and all valids, window contents
//   are not cleared and are read only after being filled.
`timescale 1ns / 1ps
`default_nettype none

module kmer_window_minimizer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kwm_in_if.sink     i_byte,
    kwm_out_if.source  o_min
);

    logic             en;
    logic             res_valid;
    kwm_pkg::t_beat   feed_beat;
    kwm_pkg::t_beat   hash_beat;
    kwm_pkg::t_result result;

    // advance everything unless a result is held up
    assign en = !res_valid || o_min.ready;

    kwm_base_feed u_feed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_byte  (i_byte),
        .o_beat  (feed_beat)
    );

    kwm_hash_tail u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_beat  (feed_beat),
        .o_beat  (hash_beat)
    );

    kwm_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_beat   (hash_beat),
        .o_valid  (res_valid),
        .o_result (result)
    );

    assign o_min.valid          = res_valid;
    assign o_min.minimizer_kmer = result.minimizer_kmer;
    assign o_min.position       = result.position;
    assign o_min.last_of_run    = result.last_of_run;

endmodule

`default_nettype wire

>>> hdl/kwm_base_feed.sv
`timescale 1ns / 1ps
`default_nettype none

module kwm_base_feed (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    kwm_in_if.sink         i_byte,
    output kwm_pkg::t_beat o_beat
);

    logic                               r_u_valid;
    logic [kwm_pkg::BYTE_W-1:0]         r_u_byte;
    logic [kwm_pkg::NB_W-1:0]           r_u_nb;
    logic [kwm_pkg::BASE_IDX_W-1:0]     r_u_j;
    logic                               r_u_first;
    logic [kwm_pkg::POS_W-1:0]          r_u_rec;

    kwm_pkg::t_kmer                     r_kmer;
    logic [kwm_pkg::SEEN_W-1:0]         r_seen;
    logic [kwm_pkg::FILL_W-1:0]         r_fill;
    logic [kwm_pkg::KIDX_W-1:0]         r_kidx;
    logic [kwm_pkg::POS_W-1:0]          r_rbase;
    kwm_pkg::t_beat                     r_beat;

    logic                               step;
    logic                               has_base;
    logic                               u_last;
    logic                               clr;
    logic [1:0]                         base;
    logic                               full;
    kwm_pkg::t_kmer                     kmer_c;
    logic [kwm_pkg::SEEN_W-1:0]         seen_c;
    logic [kwm_pkg::FILL_W-1:0]         fill_c;
    logic [kwm_pkg::KIDX_W-1:0]         kidx_c;
    logic [kwm_pkg::POS_W-1:0]          rbase_c;
    kwm_pkg::t_kmer                     n_kmer;
    logic [kwm_pkg::SEEN_W-1:0]         n_seen;
    logic [kwm_pkg::FILL_W-1:0]         n_fill;
    logic [kwm_pkg::KIDX_W-1:0]         n_kidx;
    logic [kwm_pkg::NB_W-1:0]           nb_clamped;
    kwm_pkg::t_beat                     n_beat;

    always_comb begin
        step     = i_en && r_u_valid;
        has_base = {1'b0, r_u_j} < r_u_nb;
        u_last   = ({1'b0, r_u_j} + kwm_pkg::NB_W'(1)) >= r_u_nb;
        clr      = r_u_first && (r_u_j == '0);
        base     = r_u_byte[{r_u_j, 1'b0} +: 2];

        // start of sequence: clear before this byte's first base
        kmer_c  = clr ? '0 : r_kmer;
        seen_c  = clr ? '0 : r_seen;
        fill_c  = clr ? '0 : r_fill;
        kidx_c  = clr ? '0 : r_kidx;
        rbase_c = clr ? r_u_rec : r_rbase;

        n_kmer = has_base ? kwm_pkg::KMER_W'({kmer_c, base}) : kmer_c;
        n_seen = (has_base && (seen_c < kwm_pkg::SEEN_W'(kwm_pkg::KMER_LEN)))
                 ? seen_c + kwm_pkg::SEEN_W'(1) : seen_c;
        full   = has_base && (n_seen == kwm_pkg::SEEN_W'(kwm_pkg::KMER_LEN));
        // a full window drops its oldest entry, so the fill stays put
        n_fill = (full && (fill_c != kwm_pkg::FILL_W'(kwm_pkg::WINDOW_LEN)))
                 ? fill_c + kwm_pkg::FILL_W'(1) : fill_c;
        n_kidx = full ? kidx_c + kwm_pkg::KIDX_W'(1) : kidx_c;

        n_beat.valid = step && full;
        n_beat.emit  = n_fill == kwm_pkg::FILL_W'(kwm_pkg::WINDOW_LEN);
        n_beat.last  = u_last;
        n_beat.kmer  = n_kmer;
        n_beat.hash  = kwm_pkg::mix_head(n_kmer);
        n_beat.idx0  = kidx_c - kwm_pkg::KIDX_W'(kwm_pkg::WINDOW_LEN - 1);
        n_beat.rbase = rbase_c;

        nb_clamped = (i_byte.bases_valid > kwm_pkg::NB_W'(kwm_pkg::BASES_PER_BYTE))
                     ? kwm_pkg::NB_W'(kwm_pkg::BASES_PER_BYTE) : i_byte.bases_valid;
    end

    assign i_byte.ready = i_en && (!r_u_valid || u_last);
    assign o_beat       = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_valid   <= 1'b0;
            r_u_j       <= '0;
            r_kmer      <= '0;
            r_seen      <= '0;
            r_fill      <= '0;
            r_kidx      <= '0;
            r_rbase     <= '0;
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            if (step) begin
                r_kmer  <= n_kmer;
                r_seen  <= n_seen;
                r_fill  <= n_fill;
                r_kidx  <= n_kidx;
                r_rbase <= rbase_c;
            end
            if (i_byte.valid && i_byte.ready) begin
                r_u_valid <= 1'b1;
                r_u_j     <= '0;
            end else if (step && u_last) begin
                r_u_valid <= 1'b0;
            end else if (step) begin
                r_u_j <= r_u_j + kwm_pkg::BASE_IDX_W'(1);
            end
            r_beat <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_u_byte  <= i_byte.packed_byte;
            r_u_nb    <= nb_clamped;
            r_u_first <= i_byte.first_of_sequence;
            r_u_rec   <= i_byte.record_offset;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= kwm_pkg::FILL_W'(kwm_pkg::WINDOW_LEN))
        else $error("window fill beyond window length");

    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= kwm_pkg::SEEN_W'(kwm_pkg::KMER_LEN))
        else $error("base count beyond k-mer length");

    a_fill_needs_kmer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != '0) |-> (r_seen == kwm_pkg::SEEN_W'(kwm_pkg::KMER_LEN)))
        else $error("window filled before first full k-mer");

    a_emit_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_beat.valid && r_beat.emit) |-> (r_fill == kwm_pkg::FILL_W'(kwm_pkg::WINDOW_LEN)))
        else $error("emit flagged on a partial window");

endmodule

`default_nettype wire

>>> hdl/kwm_hash_tail.sv
`timescale 1ns / 1ps
`default_nettype none

module kwm_hash_tail (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  kwm_pkg::t_beat i_beat,
    output kwm_pkg::t_beat o_beat
);

    kwm_pkg::t_beat r_beat;
    kwm_pkg::t_beat n_beat;

    assign o_beat = r_beat;

    // finish the mix
    always_comb begin
        n_beat      = i_beat;
        n_beat.hash = kwm_pkg::mix_tail(i_beat.hash);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat <= n_beat;
        end
    end

endmodule

`default_nettype wire

>>> hdl/kwm_window.sv
`timescale 1ns / 1ps
`default_nettype none

module kwm_window (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  kwm_pkg::t_beat   i_beat,
    output logic             o_valid,
    output kwm_pkg::t_result o_result
);

    kwm_pkg::t_kmer                  r_win_h [kwm_pkg::WINDOW_LEN];
    kwm_pkg::t_kmer                  r_win_k [kwm_pkg::WINDOW_LEN];
    logic                            r_c_valid;
    logic                            r_c_emit;
    logic                            r_c_last;
    logic [kwm_pkg::KIDX_W-1:0]      r_c_idx0;
    logic [kwm_pkg::POS_W-1:0]       r_c_rbase;
    logic                            r_o_valid;
    kwm_pkg::t_result                r_result;

    kwm_pkg::t_kmer                  min_h;
    kwm_pkg::t_kmer                  min_k;
    logic [kwm_pkg::WIN_IDX_W-1:0]   best;
    logic [kwm_pkg::KIDX_W-1:0]      idx;
    kwm_pkg::t_result                n_result;

    // strict compare: the earliest entry wins ties
    always_comb begin
        min_h = r_win_h[0];
        min_k = r_win_k[0];
        best  = '0;
        for (int p = 1; p < kwm_pkg::WINDOW_LEN; p++) begin
            if (r_win_h[p] < min_h) begin
                min_h = r_win_h[p];
                min_k = r_win_k[p];
                best  = kwm_pkg::WIN_IDX_W'(p);
            end
        end
        idx = r_c_idx0 + kwm_pkg::KIDX_W'(best);
        n_result.minimizer_kmer = kwm_pkg::OUT_KMER_W'(min_k);
        n_result.position       = r_c_rbase + kwm_pkg::POS_W'(idx);
        n_result.last_of_run    = r_c_last;
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= i_beat.valid;
            r_o_valid <= r_c_valid && r_c_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // advance the window by one k-mer, newest at the top
            if (i_beat.valid) begin
                for (int p = 0; p < kwm_pkg::WINDOW_LEN - 1; p++) begin
                    r_win_h[p] <= r_win_h[p+1];
                    r_win_k[p] <= r_win_k[p+1];
                end
                r_win_h[kwm_pkg::WINDOW_LEN-1] <= i_beat.hash;
                r_win_k[kwm_pkg::WINDOW_LEN-1] <= i_beat.kmer;
            end
            r_c_emit  <= i_beat.emit;
            r_c_last  <= i_beat.last;
            r_c_idx0  <= i_beat.idx0;
            r_c_rbase <= i_beat.rbase;
            r_result  <= n_result;
        end
    end

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !(r_c_valid && r_c_emit)) |=> !r_o_valid)
        else $error("result raised without an emitting k-mer");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_en && r_c_valid) |=> (r_c_valid && $stable(r_c_idx0)))
        else $error("window stage moved during stall");

endmodule

`default_nettype wire

>>> sim/kwm_minimizer_checker.sv
`timescale 1ns / 1ps

module kwm_minimizer_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    kwm_in_if    i_byte,
    kwm_out_if   o_min,
    output int   o_fail_count,
    output int   o_pending_count
);

    // Sequence state of the sketch
    kwm_pkg::t_kmer             kmer_reg;
    int                         bases_in;
    kwm_pkg::t_kmer             win_hash [kwm_pkg::WINDOW_LEN];
    kwm_pkg::t_kmer             win_kmer [kwm_pkg::WINDOW_LEN];
    int                         win_fill;
    logic [kwm_pkg::KIDX_W-1:0] kmer_count;
    logic [kwm_pkg::POS_W-1:0]  seq_base;

    kwm_pkg::t_result pending_minimizers[$];

    // Masked invertible integer mix, all arithmetic at the k-mer width
    function automatic kwm_pkg::t_kmer scramble_kmer(input kwm_pkg::t_kmer k);
        kwm_pkg::t_kmer v;
        v = ~k + (k << 21);
        v = v ^ (v >> 24);
        v = v * kwm_pkg::t_kmer'(265);
        v = v ^ (v >> 14);
        v = v * kwm_pkg::t_kmer'(21);
        v = v ^ (v >> 28);
        v = v + (v << 31);
        return v;
    endfunction

    task automatic start_sequence();
        kmer_reg   = '0;
        bases_in   = 0;
        win_fill   = 0;
        kmer_count = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns  %s: got %0h, expected %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic predict_byte(input logic [kwm_pkg::BYTE_W-1:0] pbyte,
                                input logic [kwm_pkg::NB_W-1:0] nb_raw,
                                input logic first,
                                input logic [kwm_pkg::POS_W-1:0] offset);
        int                         nb;
        int                         best;
        int                         produced;
        logic [1:0]                 base;
        logic [kwm_pkg::KIDX_W-1:0] idx;
        kwm_pkg::t_result           r;
        nb = (nb_raw > kwm_pkg::BASES_PER_BYTE) ? kwm_pkg::BASES_PER_BYTE : int'(nb_raw);
        produced = 0;
        if (first) begin
            start_sequence();
            seq_base = offset;
        end
        for (int j = 0; j < nb; j++) begin
            base = pbyte[2*j +: 2];
            kmer_reg = {kmer_reg[kwm_pkg::KMER_W-3:0], base};
            if (bases_in < kwm_pkg::KMER_LEN)
                bases_in++;
            if (bases_in < kwm_pkg::KMER_LEN)
                continue;
            // drop the oldest k-mer once the window is full
            if (win_fill == kwm_pkg::WINDOW_LEN) begin
                for (int p = 0; p < kwm_pkg::WINDOW_LEN - 1; p++) begin
                    win_hash[p] = win_hash[p+1];
                    win_kmer[p] = win_kmer[p+1];
                end
                win_fill--;
            end
            win_hash[win_fill] = scramble_kmer(kmer_reg);
            win_kmer[win_fill] = kmer_reg;
            win_fill++;
            if (win_fill == kwm_pkg::WINDOW_LEN) begin
                best = 0;
                for (int p = 1; p < kwm_pkg::WINDOW_LEN; p++)
                    if (win_hash[p] < win_hash[best])
                        best = p;
                idx = kmer_count - kwm_pkg::KIDX_W'(kwm_pkg::WINDOW_LEN - 1)
                      + kwm_pkg::KIDX_W'(best);
                r.minimizer_kmer = kwm_pkg::OUT_KMER_W'(win_kmer[best]);
                r.position       = seq_base + kwm_pkg::POS_W'(idx);
                r.last_of_run    = 1'b0;
                pending_minimizers = {pending_minimizers, r};
                produced++;
            end
            kmer_count++;
        end
        if (produced > 0)
            pending_minimizers[pending_minimizers.size()-1].last_of_run = 1'b1;
    endtask

    always @(posedge i_clk) begin
        kwm_pkg::t_result want;
        if (!i_rst_n) begin
            start_sequence();
            seq_base = '0;
            pending_minimizers.delete();
        end else begin
            if (i_byte.valid && i_byte.ready)
                predict_byte(i_byte.packed_byte, i_byte.bases_valid,
                             i_byte.first_of_sequence, i_byte.record_offset);
            if (o_min.valid && o_min.ready) begin
                if (pending_minimizers.size() == 0) begin
                    report_mismatch("unexpected minimizer", 64'(o_min.minimizer_kmer), '0);
                end else begin
                    want = pending_minimizers[0];
                    pending_minimizers.delete(0);
                    if (o_min.minimizer_kmer !== want.minimizer_kmer)
                        report_mismatch("minimizer_kmer", 64'(o_min.minimizer_kmer),
                                        64'(want.minimizer_kmer));
                    if (o_min.position !== want.position)
                        report_mismatch("position", 64'(o_min.position),
                                        64'(want.position));
                    if (o_min.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 64'(o_min.last_of_run),
                                        64'(want.last_of_run));
                end
            end
        end
        o_pending_count = pending_minimizers.size();
    end

endmodule

>>> sim/kmer_window_minimizer_top_test.sv
`timescale 1ns / 1ps

module kmer_window_minimizer_top_test;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int TARGET_BYTES = 400;

    logic i_clk;
    logic i_rst_n;

    kwm_in_if  byte_ch ();
    kwm_out_if min_ch ();

    int fail_count;
    int pending_count;
    int bytes_sent;
    int cycle_count;
    int hold_left;
    int calm_left;
    bit burst;

    kmer_window_minimizer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_min   (min_ch)
    );

    kwm_minimizer_checker u_minimizer_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte          (byte_ch),
        .o_min           (min_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [kwm_pkg::POS_W-1:0] pick_offset();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return {kwm_pkg::POS_W{1'b1}} - kwm_pkg::POS_W'($urandom_range(0, 40));
        else if (r == 1)
            return kwm_pkg::POS_W'($urandom_range(0, 50));
        return {8'($urandom_range(0, 255)), 32'($urandom)};
    endfunction

    function automatic logic [kwm_pkg::NB_W-1:0] pick_count();
        if ($urandom_range(0, 9) < 8)
            return kwm_pkg::NB_W'(kwm_pkg::BASES_PER_BYTE);
        return kwm_pkg::NB_W'($urandom_range(0, 7));
    endfunction

    // Result side: random holds, with calm stretches of steady ready
    initial begin
        min_ch.ready = 1'b0;
        hold_left = 0;
        calm_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                min_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                min_ch.ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 99) < 2)
                    calm_left = $urandom_range(50, 300);
                else if ($urandom_range(0, 3) == 0)
                    hold_left = pick_gap();
            end
        end
    end

    task automatic idle_for(input int n);
        if (n > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic send_byte(input logic [kwm_pkg::BYTE_W-1:0] b,
                             input logic [kwm_pkg::NB_W-1:0] nb,
                             input logic first,
                             input logic [kwm_pkg::POS_W-1:0] offset);
        byte_ch.valid             <= 1'b1;
        byte_ch.packed_byte       <= b;
        byte_ch.bases_valid       <= nb;
        byte_ch.first_of_sequence <= first;
        byte_ch.record_offset     <= offset;
        do @(posedge i_clk); while (!byte_ch.ready);
        @(negedge i_clk);
        bytes_sent++;
        if (!burst)
            idle_for(pick_gap());
    endtask

    task automatic wait_for_drain();
        byte_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int  kind;
        int  len;
        bit  drained;
        i_rst_n                   = 1'b0;
        byte_ch.valid             = 1'b0;
        byte_ch.packed_byte       = '0;
        byte_ch.bases_valid       = '0;
        byte_ch.first_of_sequence = 1'b0;
        byte_ch.record_offset     = '0;
        bytes_sent = 0;
        burst      = 1'b0;
        drained    = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // continue the reset sequence without a start flag, record base zero
        send_byte(8'h00, 3'd4, 1'b0, 40'h12_3456_789A);
        send_byte(8'hFF, 3'd4, 1'b0, '0);
        send_byte(8'h00, 3'd4, 1'b0, '0);
        send_byte(8'hFF, 3'd4, 1'b0, '0);
        send_byte(8'h00, 3'd4, 1'b0, '0);
        send_byte(8'hFF, 3'd4, 1'b0, '0);
        // start at the top of the offset range; position wraps
        send_byte(8'hE4, 3'd0, 1'b1, {kwm_pkg::POS_W{1'b1}});
        send_byte(8'hFF, 3'd7, 1'b0, '0);
        send_byte(8'h00, 3'd5, 1'b0, '0);
        send_byte(8'h1B, 3'd6, 1'b0, '0);
        send_byte(8'h03, 3'd1, 1'b0, '0);
        send_byte(8'hC6, 3'd2, 1'b0, '0);
        send_byte(8'h9C, 3'd3, 1'b0, '0);
        send_byte(8'h55, 3'd4, 1'b0, '0);
        send_byte(8'hAA, 3'd4, 1'b0, '0);
        send_byte(8'hFF, 3'd0, 1'b0, '0);
        send_byte(8'hFF, 3'd4, 1'b0, '0);
        send_byte(8'h00, 3'd4, 1'b0, '0);
        send_byte(8'hE4, 3'd4, 1'b0, '0);
        send_byte(8'h39, 3'd4, 1'b0, '0);
        // too short for a full window: nothing comes out
        send_byte(8'hFF, 3'd4, 1'b1, '0);
        send_byte(8'h00, 3'd4, 1'b0, '0);
        send_byte(8'h5A, 3'd4, 1'b0, '0);
        send_byte(8'hA5, 3'd4, 1'b0, '0);
        send_byte(8'hFF, 3'd4, 1'b0, '0);

        while (bytes_sent < TARGET_BYTES) begin
            kind  = $urandom_range(0, 9);
            burst = ($urandom_range(0, 5) == 0);
            if (kind < 7) begin
                len = $urandom_range(6, 40);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom_range(0, 255)), pick_count(), i == 0,
                              pick_offset());
            end else if (kind < 8) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom_range(0, 255)), pick_count(), i == 0,
                              pick_offset());
            end else begin
                // noise: random flags and counts, broken sequences
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom_range(0, 255)),
                              kwm_pkg::NB_W'($urandom_range(0, 7)),
                              1'($urandom_range(0, 1)), pick_offset());
            end
            burst = 1'b0;
            if (!drained && bytes_sent > TARGET_BYTES / 2) begin
                wait_for_drain();
                drained = 1'b1;
            end
        end

        byte_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
